// ----- sv/ewgm_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the ellipse gridder.
package ewgm_pkg;

  // Point store geometry
  localparam int MAX_POINTS    = 1024;
  localparam int ROT_FRAC_BITS = 14;
  localparam int ADDR_W        = $clog2(MAX_POINTS);
  localparam int CNT_W         = $clog2(MAX_POINTS + 1);
  localparam int PT_W          = 24 + 24 + 32;
  localparam int SUM_W         = 32 + ADDR_W;
  localparam int DIVCNT_W      = $clog2(SUM_W + 1);
  localparam int LHS_W         = 116;

  // Item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Metric selector codes
  localparam logic [2:0] METRIC_MEAN    = 3'd0;
  localparam logic [2:0] METRIC_NEAREST = 3'd1;
  localparam logic [2:0] METRIC_MIN     = 3'd2;
  localparam logic [2:0] METRIC_MAX     = 3'd3;
  localparam logic [2:0] METRIC_RANGE   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_METRIC  = 3'd0;
  localparam logic [2:0] CFG_RADIUS1 = 3'd1;
  localparam logic [2:0] CFG_RADIUS2 = 3'd2;
  localparam logic [2:0] CFG_COS     = 3'd3;
  localparam logic [2:0] CFG_SIN     = 3'd4;
  localparam logic [2:0] CFG_MINPTS  = 3'd5;
  localparam logic [2:0] CFG_NODATA  = 3'd6;

  localparam logic signed [15:0] COS_RESET = 16'(1 << ROT_FRAC_BITS);

  // Controller to datapath commands
  typedef struct packed {
    logic              ram_we;
    logic [ADDR_W-1:0] addr;
    logic              issue;
    logic              query_start;
    logic              div_start;
    logic              emit;
  } ewgm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_empty;
    logic need_div;
    logic div_busy;
  } ewgm_sts_t;

endpackage

// ----- sv/ellipse_window_grid_metric_unit.sv -----
// Top level of the elliptical-window scattered-data gridder.
// Load and clear transfers leave busy low, so the next item may follow.
// A query over N >= 1 points walks the store one point a cycle through an 11-stage test
// pipeline before its result strobe; with an empty store the walk is skipped, and a mean
// adds a shift-subtract division. The result strobe lasts one cycle, cannot stall.
// Synchronous active-low reset empties the store count and restores register defaults.
module ellipse_window_grid_metric_unit import ewgm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  input  logic signed [31:0] in_value_z,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [CNT_W-1:0]   out_points_found,
  output logic               out_no_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  ewgm_cmd_t cmd;
  ewgm_sts_t sts;

  ewgm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  ewgm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_value_z       (in_value_z),
    .cmd              (cmd),
    .sts              (sts),
    .out_value        (out_value),
    .out_points_found (out_points_found),
    .out_no_data      (out_no_data),
    .out_valid        (out_valid)
  );

endmodule

// ----- sv/ewgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ewgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ewgm_ctrl.sv -----
// Controller: point count, store walk sequencing, division and result timing.
module ewgm_ctrl import ewgm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  ewgm_sts_t  sts,
  output ewgm_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_FINISH = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // Next state and command decode
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    cmd.ram_we      = 1'b0;
    cmd.issue       = 1'b0;
    cmd.query_start = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.emit        = 1'b0;
    cmd.addr        = idx_r[ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD: begin
              if (count_r < CNT_W'(MAX_POINTS)) begin
                cmd.ram_we = 1'b1;
                cmd.addr   = count_r[ADDR_W-1:0];
                count_nxt  = count_r + 1'b1;
              end
            end
            MODE_CLEAR: count_nxt = '0;
            MODE_QUERY: begin
              cmd.query_start = 1'b1;
              idx_nxt         = '0;
              state_nxt       = (count_r == '0) ? ST_DRAIN : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (idx_r + 1'b1 == count_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- sv/ewgm_dp.sv -----
// Datapath: config registers, point store, ellipse test pipeline, accumulators, divider.
module ewgm_dp import ewgm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  input  logic signed [31:0] in_value_z,
  input  ewgm_cmd_t          cmd,
  output ewgm_sts_t          sts,
  output logic signed [31:0] out_value,
  output logic [CNT_W-1:0]   out_points_found,
  output logic               out_no_data,
  output logic               out_valid
);

  // Configuration registers
  logic [2:0]         metric_r;
  logic [15:0]        r1_r, r2_r;
  logic signed [15:0] cos_r, sin_r;
  logic [10:0]        minp_r;
  logic signed [31:0] nodata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_MEAN;
      r1_r     <= '0;
      r2_r     <= '0;
      cos_r    <= COS_RESET;
      sin_r    <= '0;
      minp_r   <= '0;
      nodata_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_METRIC:  metric_r <= cfg_wdata[2:0];
        CFG_RADIUS1: r1_r     <= cfg_wdata[15:0];
        CFG_RADIUS2: r2_r     <= cfg_wdata[15:0];
        CFG_COS:     cos_r    <= cfg_wdata[15:0];
        CFG_SIN:     sin_r    <= cfg_wdata[15:0];
        CFG_MINPTS:  minp_r   <= cfg_wdata[10:0];
        CFG_NODATA:  nodata_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squared radii and ellipse bound, refreshed every cycle
  logic [31:0]      sq1_r, sq2_r;
  logic [63:0]      prod_r;
  logic [LHS_W-1:0] bound;

  always_ff @(posedge clk) begin
    sq1_r  <= 32'(r1_r) * 32'(r1_r);
    sq2_r  <= 32'(r2_r) * 32'(r2_r);
    prod_r <= 64'(sq1_r) * 64'(sq2_r);
  end
  assign bound = LHS_W'({prod_r, {(2 * ROT_FRAC_BITS){1'b0}}});

  // Point store
  logic [PT_W-1:0]    rd;
  logic signed [23:0] px, py;
  logic signed [31:0] pz;

  ewgm_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (cmd.addr),
    .wdata ({in_coord_x, in_coord_y, in_value_z}),
    .raddr (cmd.addr),
    .rdata (rd)
  );
  assign px = rd[PT_W-1 -: 24];
  assign py = rd[PT_W-25 -: 24];
  assign pz = rd[31:0];

  // Query node
  logic signed [23:0] node_x_r, node_y_r;
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      node_x_r <= in_coord_x;
      node_y_r <= in_coord_y;
    end
  end

  // Stage valids: bit 0 is the read data, bit 10 the inside flag
  logic [10:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[9:0], cmd.issue};
    end
  end
  assign sts.pipe_empty = ~|v_r;

  // Ellipse test pipeline
  logic signed [31:0] zp_r [10];
  logic signed [24:0] dx_r, dy_r;
  logic signed [40:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic signed [41:0] rx_r, ry_r;
  logic [40:0]        mx_r, my_r;
  logic [41:0]        xhh_r, yhh_r;
  logic [40:0]        xhl_r, yhl_r;
  logic [39:0]        xll_r, yll_r;
  logic [81:0]        rx2_r, ry2_r;
  logic [59:0]        tx0_r, tx1_r, ty0_r, ty1_r;
  logic [57:0]        tx2_r, ty2_r;
  logic [82:0]        d7_r, d8_r, d9_r, d10_r;
  logic [LHS_W-1:0]   t1_r, t2_r, lhs_r;
  logic               inside_r;

  always_ff @(posedge clk) begin
    zp_r[0] <= pz;
    for (int k = 1; k < 10; k++) begin
      zp_r[k] <= zp_r[k-1];
    end
    // offsets
    dx_r <= px - node_x_r;
    dy_r <= py - node_y_r;
    // rotation products
    pxc_r <= dx_r * cos_r;
    pys_r <= dy_r * sin_r;
    pyc_r <= dy_r * cos_r;
    pxs_r <= dx_r * sin_r;
    rx_r  <= pxc_r + pys_r;
    ry_r  <= pyc_r - pxs_r;
    // magnitudes
    mx_r <= rx_r[41] ? 41'(-rx_r) : 41'(rx_r);
    my_r <= ry_r[41] ? 41'(-ry_r) : 41'(ry_r);
    // squares from split halves
    xhh_r <= 42'(mx_r[40:20]) * 42'(mx_r[40:20]);
    xhl_r <= 41'(mx_r[40:20]) * 41'(mx_r[19:0]);
    xll_r <= 40'(mx_r[19:0]) * 40'(mx_r[19:0]);
    yhh_r <= 42'(my_r[40:20]) * 42'(my_r[40:20]);
    yhl_r <= 41'(my_r[40:20]) * 41'(my_r[19:0]);
    yll_r <= 40'(my_r[19:0]) * 40'(my_r[19:0]);
    rx2_r <= (82'(xhh_r) << 40) + (82'(xhl_r) << 21) + 82'(xll_r);
    ry2_r <= (82'(yhh_r) << 40) + (82'(yhl_r) << 21) + 82'(yll_r);
    // weighting by squared radii, cut into partial products
    tx0_r <= 60'(rx2_r[27:0]) * 60'(sq2_r);
    tx1_r <= 60'(rx2_r[55:28]) * 60'(sq2_r);
    tx2_r <= 58'(rx2_r[81:56]) * 58'(sq2_r);
    ty0_r <= 60'(ry2_r[27:0]) * 60'(sq1_r);
    ty1_r <= 60'(ry2_r[55:28]) * 60'(sq1_r);
    ty2_r <= 58'(ry2_r[81:56]) * 58'(sq1_r);
    d7_r  <= 83'(rx2_r) + 83'(ry2_r);
    t1_r  <= LHS_W'(tx0_r) + (LHS_W'(tx1_r) << 28) + (LHS_W'(tx2_r) << 56);
    t2_r  <= LHS_W'(ty0_r) + (LHS_W'(ty1_r) << 28) + (LHS_W'(ty2_r) << 56);
    d8_r  <= d7_r;
    lhs_r <= t1_r + t2_r;
    d9_r  <= d8_r;
    inside_r <= (lhs_r <= bound);
    d10_r    <= d9_r;
  end

  // Accumulators over kept points
  logic [CNT_W-1:0]   n_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [31:0] zmin_r, zmax_r, near_z_r;
  logic [82:0]        near_d_r;
  logic               hit;
  logic signed [31:0] zin;

  assign hit = v_r[10] & inside_r;
  assign zin = zp_r[9];

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      n_r <= '0;
    end else if (hit) begin
      n_r <= n_r + 1'b1;
      if (n_r == '0) begin
        sum_r    <= SUM_W'(zin);
        zmin_r   <= zin;
        zmax_r   <= zin;
        near_d_r <= d10_r;
        near_z_r <= zin;
      end else begin
        sum_r <= sum_r + zin;
        if (zin < zmin_r) zmin_r <= zin;
        if (zin > zmax_r) zmax_r <= zin;
        if (d10_r < near_d_r) begin
          near_d_r <= d10_r;
          near_z_r <= zin;
        end
      end
    end
  end

  logic count_ok;
  assign count_ok     = (n_r != '0) && (n_r >= minp_r);
  assign sts.need_div = (metric_r == METRIC_MEAN) && count_ok;

  // Restoring divider on magnitudes, one quotient bit a cycle
  logic [SUM_W-1:0]    q_r;
  logic [CNT_W-1:0]    rem_r;
  logic [DIVCNT_W-1:0] dcnt_r;
  logic                neg_r, div_busy_r;
  logic [CNT_W:0]      trial;
  logic [SUM_W-1:0]    quot;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign quot  = neg_r ? -q_r : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && dcnt_r == DIVCNT_W'(1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r  <= sum_r[SUM_W-1];
      q_r    <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rem_r  <= '0;
      dcnt_r <= DIVCNT_W'(SUM_W);
    end else if (div_busy_r) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (trial >= {1'b0, n_r}) begin
        rem_r <= CNT_W'(trial - {1'b0, n_r});
        q_r   <= {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[CNT_W-1:0];
        q_r   <= {q_r[SUM_W-2:0], 1'b0};
      end
    end
  end
  assign sts.div_busy = div_busy_r;

  // Metric selection and result register
  logic signed [32:0] range_w;
  logic signed [31:0] range_sat, metric_val;
  logic               nd;

  assign range_w   = 33'(zmax_r) - 33'(zmin_r);
  assign range_sat = range_w[31] ? 32'sh7fffffff : range_w[31:0];

  always_comb begin
    if (metric_r == METRIC_NEAREST) begin
      nd = (n_r == '0);
    end else begin
      nd = (metric_r > METRIC_RANGE) || !count_ok;
    end
    case (metric_r)
      METRIC_MEAN:    metric_val = quot[31:0];
      METRIC_NEAREST: metric_val = near_z_r;
      METRIC_MIN:     metric_val = zmin_r;
      METRIC_MAX:     metric_val = zmax_r;
      METRIC_RANGE:   metric_val = range_sat;
      default:        metric_val = nodata_r;
    endcase
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  logic signed [31:0] out_value_r;
  logic [CNT_W-1:0]   out_points_r;
  logic               out_no_data_r;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r   <= nd ? nodata_r : metric_val;
      out_points_r  <= n_r;
      out_no_data_r <= nd;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_points_found = out_points_r;
  assign out_no_data      = out_no_data_r;

endmodule

// ----- sv/ewgm_chk.sv -----
// Port-level checker for the gridder top level, with its bind.
module ewgm_chk import ewgm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic [CNT_W-1:0]   out_points_found
);

  // a query transfer makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_QUERY |=> busy)
    else $error("query transfer did not raise busy");

  // loads, clears and ignored modes never block the next item
  a_other_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode != MODE_QUERY |=> !busy)
    else $error("non-query transfer raised busy");

  // a result only closes a query in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without a query in progress");

  // single-cycle strobe
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // found count never exceeds the store depth
  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_points_found <= CNT_W'(MAX_POINTS))
    else $error("points_found beyond store depth");

endmodule

bind ellipse_window_grid_metric_unit ewgm_chk u_chk (.*);

// ----- test/tb_top.sv -----
// Testbench for the elliptical-window gridder: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import ewgm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 100;
  localparam logic signed [31:0] Z_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Z_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [31:0] value;
    logic [CNT_W-1:0]   pts;
    logic               nd;
  } node_result_t;

  // One row of the directed table: an item or a register write
  typedef struct {
    bit       is_cfg;
    logic [1:0] mode;
    int       x;
    int       y;
    int       z;
    bit       typed;
    int       ev;
    int       ep;
    bit       en;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  logic signed [23:0] in_coord_x;
  logic signed [23:0] in_coord_y;
  logic signed [31:0] in_value_z;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic [CNT_W-1:0]   out_points_found;
  logic               out_no_data;
  logic               cfg_we;
  logic [2:0]         cfg_addr;
  logic [31:0]        cfg_wdata;

  ellipse_window_grid_metric_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gridder shadow state
  logic [2:0]         sh_metric;
  logic [15:0]        sh_r1;
  logic [15:0]        sh_r2;
  logic signed [15:0] sh_cos;
  logic signed [15:0] sh_sin;
  logic [10:0]        sh_minpts;
  logic signed [31:0] sh_nodata;
  logic signed [23:0] pt_x [MAX_POINTS];
  logic signed [23:0] pt_y [MAX_POINTS];
  logic signed [31:0] pt_z [MAX_POINTS];
  int                 pt_count;

  node_result_t pending_results[$];
  int           mismatches;
  int           idle_cycles = 0;
  int           burst_left;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Exact window test and metric for one grid node
  function automatic node_result_t grid_node(logic signed [23:0] nx, logic signed [23:0] ny);
    node_result_t r;
    longint       dx, dy, rx, ry, sum, zmin, zmax, near_z, res, z;
    logic [63:0]  ax, ay;
    logic [127:0] sq1, sq2, bound, rx2, ry2, lhs, sq_dist, near_d;
    int           n;
    bit           near_ok, nd;
    sq1 = {112'b0, sh_r1} * {112'b0, sh_r1};
    sq2 = {112'b0, sh_r2} * {112'b0, sh_r2};
    bound = (sq1 * sq2) << (2 * ROT_FRAC_BITS);
    n = 0; sum = 0; zmin = 0; zmax = 0; near_z = 0; res = 0;
    near_ok = 0; nd = 0; near_d = '0;
    for (int i = 0; i < pt_count; i++) begin
      dx = longint'(pt_x[i]) - longint'(nx);
      dy = longint'(pt_y[i]) - longint'(ny);
      rx = dx * longint'(sh_cos) + dy * longint'(sh_sin);
      ry = dy * longint'(sh_cos) - dx * longint'(sh_sin);
      ax = (rx < 0) ? -rx : rx;
      ay = (ry < 0) ? -ry : ry;
      rx2 = {64'b0, ax} * {64'b0, ax};
      ry2 = {64'b0, ay} * {64'b0, ay};
      lhs = rx2 * sq2 + ry2 * sq1;
      if (lhs > bound) continue;
      z = longint'(pt_z[i]);
      if (n == 0) begin
        zmin = z;
        zmax = z;
      end else begin
        if (z < zmin) zmin = z;
        if (z > zmax) zmax = z;
      end
      sum += z;
      n++;
      sq_dist = rx2 + ry2;
      // first kept point wins ties
      if (!near_ok || sq_dist < near_d) begin
        near_ok = 1;
        near_d = sq_dist;
        near_z = z;
      end
    end
    if (sh_metric == METRIC_NEAREST) begin
      if (near_ok) res = near_z; else nd = 1;
    end else if (sh_metric > METRIC_RANGE || n == 0 || n < int'(sh_minpts)) begin
      nd = 1;
    end else if (sh_metric == METRIC_MEAN) begin
      res = sum / longint'(n);
    end else if (sh_metric == METRIC_MIN) begin
      res = zmin;
    end else if (sh_metric == METRIC_MAX) begin
      res = zmax;
    end else begin
      res = zmax - zmin;
    end
    if (nd) res = longint'(sh_nodata);
    if (res > longint'(Z_MAX)) res = longint'(Z_MAX);
    if (res < longint'(Z_MIN)) res = longint'(Z_MIN);
    r.value = res[31:0];
    r.pts   = n[CNT_W-1:0];
    r.nd    = nd;
    return r;
  endfunction

  // Update shadow state for one accepted transfer
  task automatic take_item(logic [1:0] mode, logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [31:0] z, bit typed, node_result_t want);
    case (mode)
      MODE_LOAD: begin
        if (pt_count < MAX_POINTS) begin
          pt_x[pt_count] = x;
          pt_y[pt_count] = y;
          pt_z[pt_count] = z;
          pt_count++;
        end
      end
      MODE_CLEAR: pt_count = 0;
      MODE_QUERY: pending_results.push_back(typed ? want : grid_node(x, y));
      default: ;
    endcase
  endtask

  // Present one item, with burst-style gaps, and wait for its transfer
  task automatic send_item(logic [1:0] mode, int x, int y, int z, bit typed,
                           node_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      burst_left = $urandom_range(1, 16);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= mode;
    in_coord_x <= x[23:0];
    in_coord_y <= y[23:0];
    in_value_z <= z;
    do @(posedge clk); while (busy);
    take_item(mode, x[23:0], y[23:0], z, typed, want);
  endtask

  // Drain everything; loads may still be in flight after the last result
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_METRIC:  sh_metric = data[2:0];
      CFG_RADIUS1: sh_r1     = data[15:0];
      CFG_RADIUS2: sh_r2     = data[15:0];
      CFG_COS:     sh_cos    = data[15:0];
      CFG_SIN:     sh_sin    = data[15:0];
      CFG_MINPTS:  sh_minpts = data[10:0];
      CFG_NODATA:  sh_nodata = data;
      default: ;
    endcase
  endtask

  // Result checker: one strobe, one transfer, oldest expectation first
  always @(posedge clk) begin
    node_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result value", out_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_points_found !== want.pts)
          report_mismatch("points_found", out_points_found, want.pts);
        if (out_no_data !== want.nd) report_mismatch("no_data", out_no_data, want.nd);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL ellipse_window_grid_metric_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed table, expectations typed in where obvious
  dir_row_t dir_rows [] = '{
    '{0, MODE_QUERY, 0, 0, 0, 1, 0, 0, 1},
    '{0, MODE_LOAD, 8388607, -8388608, 32'sh7fff_ffff, 0, 0, 0, 0},
    '{0, MODE_LOAD, -8388608, 8388607, 32'sh7fff_ffff, 0, 0, 0, 0},
    '{0, MODE_QUERY, 0, 0, 0, 1, 32'sh7fff_ffff, 2, 0},
    '{0, MODE_LOAD, 0, 0, 32'sh8000_0000, 0, 0, 0, 0},
    '{0, MODE_QUERY, -8388608, -8388608, 0, 1, 715827882, 3, 0},
    '{0, MODE_UNUSED, 77, -77, 5, 0, 0, 0, 0},
    '{0, MODE_QUERY, 8388607, 8388607, -1, 1, 715827882, 3, 0},
    '{0, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0},
    '{0, MODE_QUERY, 3, 4, 0, 1, 0, 0, 1},
    '{0, MODE_LOAD, 5, -7, -1234, 0, 0, 0, 0},
    '{0, MODE_LOAD, 5, -7, 99, 0, 0, 0, 0},
    '{0, MODE_QUERY, 5, -7, 0, 1, -567, 2, 0},
    '{1, 0, int'(CFG_METRIC), 0, int'(METRIC_RANGE), 0, 0, 0, 0},
    '{0, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0},
    '{0, MODE_LOAD, 0, 0, 32'sh8000_0000, 0, 0, 0, 0},
    '{0, MODE_LOAD, 1, 1, 32'sh7fff_ffff, 0, 0, 0, 0},
    '{0, MODE_QUERY, 0, 0, 0, 1, 32'sh7fff_ffff, 2, 0},
    '{1, 0, int'(CFG_METRIC), 0, int'(METRIC_NEAREST), 0, 0, 0, 0},
    '{1, 0, int'(CFG_RADIUS1), 0, 10, 0, 0, 0, 0},
    '{1, 0, int'(CFG_RADIUS2), 0, 10, 0, 0, 0, 0},
    '{0, MODE_QUERY, 1, 1, 0, 1, 32'sh7fff_ffff, 2, 0},
    '{0, MODE_QUERY, 2, 0, 0, 0, 0, 0, 0},
    '{1, 0, int'(CFG_METRIC), 0, 7, 0, 0, 0, 0},
    '{0, MODE_QUERY, 0, 0, 0, 1, 0, 2, 1},
    '{1, 0, int'(CFG_NODATA), 0, 32'sh8000_0000, 0, 0, 0, 0},
    '{0, MODE_QUERY, 0, 0, 0, 1, 32'sh8000_0000, 2, 1}
  };

  initial begin
    node_result_t want, none;
    int           span, cx, cy, roll;
    logic [31:0]  rv [7];
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_mode    <= MODE_LOAD;
    in_coord_x <= '0;
    in_coord_y <= '0;
    in_value_z <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= CFG_METRIC;
    cfg_wdata  <= '0;
    mismatches = 0;
    burst_left = 0;
    none = '{0, 0, 0};
    sh_metric = METRIC_MEAN;
    sh_r1 = '0;
    sh_r2 = '0;
    sh_cos = COS_RESET;
    sh_sin = '0;
    sh_minpts = '0;
    sh_nodata = '0;
    pt_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].x[2:0], dir_rows[i].z);
      end else begin
        want = '{dir_rows[i].ev, dir_rows[i].ep[CNT_W-1:0], dir_rows[i].en};
        send_item(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].typed, want);
      end
    end

    // Random phases, each with a fresh register setting
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      rv[CFG_METRIC]  = (ph == 9) ? 32'(5 + $urandom_range(0, 2)) : 32'(ph % 5);
      rv[CFG_RADIUS1] = $urandom_range(1, 3000);
      rv[CFG_RADIUS2] = $urandom_range(1, 3000);
      rv[CFG_COS]     = 32'($signed($urandom_range(0, 32768)) - 16384);
      rv[CFG_SIN]     = 32'($signed($urandom_range(0, 32768)) - 16384);
      rv[CFG_MINPTS]  = $urandom_range(0, 4);
      rv[CFG_NODATA]  = $urandom;
      case (ph)
        1: rv[CFG_RADIUS1] = 0;
        2: begin
          rv[CFG_RADIUS1] = 16'hffff;
          rv[CFG_RADIUS2] = 16'hffff;
          rv[CFG_NODATA]  = Z_MAX;
        end
        3: begin
          rv[CFG_COS] = 0;
          rv[CFG_SIN] = 0;
        end
        4: begin
          rv[CFG_COS] = 32'(-16384);
          rv[CFG_SIN] = 16384;
        end
        5: rv[CFG_MINPTS] = 1024;
        6: rv[CFG_RADIUS2] = 0;
        7: begin
          rv[CFG_RADIUS1] = 0;
          rv[CFG_RADIUS2] = 0;
          rv[CFG_NODATA]  = Z_MIN;
        end
        default: ;
      endcase
      for (int r = 0; r < 7; r++) write_reg(r[2:0], rv[r]);
      span = (sh_r1 > sh_r2) ? int'(sh_r1) : int'(sh_r2);
      span = (span == 0) ? 1000 : span + span / 2;
      cx = $signed($urandom_range(0, 16000000)) - 8000000;
      cy = $signed($urandom_range(0, 16000000)) - 8000000;
      send_item(MODE_CLEAR, 0, 0, 0, 0, none);
      for (int k = 0; k < 40; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          send_item(MODE_LOAD, cx + $signed($urandom_range(0, 2 * span)) - span,
                    cy + $signed($urandom_range(0, 2 * span)) - span,
                    ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 2000)) - 1000,
                    0, none);
        end else if (roll < 82) begin
          send_item(MODE_QUERY, cx + $signed($urandom_range(0, span)) - span / 2,
                    cy + $signed($urandom_range(0, span)) - span / 2, $urandom, 0, none);
        end else if (roll < 87) begin
          send_item(MODE_CLEAR, $urandom, $urandom, $urandom, 0, none);
        end else begin
          // noise over the whole field range, any mode
          send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 0, none);
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS ellipse_window_grid_metric_unit");
    end else begin
      $display("FAIL ellipse_window_grid_metric_unit");
    end
    $finish;
  end

endmodule
